// ===== hw/rtl/rpip_pkg.sv =====
// ----------------------------------------------------------------------------
// rpip_pkg
// Shared widths and beat types for the radix prefixed integer parser.
// ----------------------------------------------------------------------------
package rpip_pkg;

    // Width of the internal accumulator; the result is always 32 bits.
    localparam int VALUE_BITS  = 32;
    localparam int RESULT_BITS = 32;

    // One character beat on the input channel.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_beat_t;

    // One result beat on the output channel.
    typedef struct packed {
        logic                           parse_ok;
        logic signed [RESULT_BITS-1:0]  value;
    } result_beat_t;

    // End-of-argument summary handed from the parser core to the formatter.
    typedef struct packed {
        logic                  fire;
        logic                  ok;
        logic                  negative;
        logic [VALUE_BITS-1:0] acc;
    } finish_t;

endpackage

// ===== hw/rtl/rpip_core.sv =====
// ----------------------------------------------------------------------------
// rpip_core
// Parser state machine and accumulator, updated once per accepted character.
// ----------------------------------------------------------------------------
module rpip_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  rpip_pkg::char_beat_t beat,
    output rpip_pkg::finish_t   finish
);

    typedef enum logic [3:0] {
        PH_SKIP,
        PH_ZERO,
        PH_SIGN,
        PH_DEC,
        PH_HEX,
        PH_BIN,
        PH_DONE,
        PH_ERR
    } phase_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam int VB = rpip_pkg::VALUE_BITS;

    phase_t        phase_reg, phase_next;
    logic [VB-1:0] acc_reg, acc_next;
    logic          neg_reg, neg_next;
    logic          hnp_reg, hnp_next;
    logic          dig_reg, dig_next;

    logic [7:0]    c;
    logic          is_dec;
    logic          is_ws;
    logic          is_hex;
    logic [3:0]    nibble;
    logic [3:0]    dec_val;
    logic [VB-1:0] acc_x10;
    logic          ok_now;

    // Character classification.
    always_comb
    begin
        c       = beat.char_code;
        is_dec  = (c >= CH_ZERO) && (c <= CH_NINE);
        is_ws   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
        dec_val = 4'(c - CH_ZERO);
        nibble  = 4'd0;
        is_hex  = 1'b1;
        if (is_dec)
        begin
            nibble = dec_val;
        end
        else if ((c >= CH_LA) && (c <= CH_LF_HEX))
        begin
            nibble = 4'(c - CH_LA + 8'd10);
        end
        else if ((c >= CH_UA) && (c <= CH_UF))
        begin
            nibble = 4'(c - CH_UA + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
        // Times ten plus the digit as two shifts and two adds, wrapping at the accumulator width.
        acc_x10 = (acc_reg << 3) + (acc_reg << 1) + VB'(dec_val);
    end

    // Next parser state for the current character.
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        hnp_next   = hnp_reg;
        dig_next   = dig_reg;

        case (phase_reg)
            PH_SKIP:
            begin
                if (is_ws)
                begin
                    phase_next = PH_SKIP;
                end
                else if (c == CH_ZERO)
                begin
                    phase_next = PH_ZERO;
                    dig_next   = 1'b1;
                end
                else if (c == CH_MINUS)
                begin
                    phase_next = PH_SIGN;
                    neg_next   = 1'b1;
                end
                else if (is_dec)
                begin
                    acc_next   = VB'(dec_val);
                    dig_next   = 1'b1;
                    phase_next = PH_DEC;
                end
                else
                begin
                    phase_next = PH_ERR;
                end
            end
            PH_ZERO:
            begin
                if (c == CH_X)
                begin
                    phase_next = PH_HEX;
                    dig_next   = 1'b0;
                end
                else if (c == CH_B)
                begin
                    phase_next = PH_BIN;
                    dig_next   = 1'b0;
                end
                else if (is_dec)
                begin
                    acc_next   = VB'(dec_val);
                    phase_next = PH_DEC;
                end
                else if (is_ws)
                begin
                    phase_next = (dig_reg && !hnp_reg) ? PH_DONE : PH_ERR;
                end
                else
                begin
                    phase_next = PH_ERR;
                end
            end
            PH_SIGN, PH_DEC:
            begin
                if (is_dec)
                begin
                    acc_next   = acc_x10;
                    dig_next   = 1'b1;
                    phase_next = PH_DEC;
                end
                else if (is_ws)
                begin
                    phase_next = (dig_reg && !hnp_reg) ? PH_DONE : PH_ERR;
                end
                else
                begin
                    phase_next = PH_ERR;
                end
            end
            PH_HEX:
            begin
                if (is_hex)
                begin
                    acc_next = {acc_reg[VB-5:0], nibble};
                    if (hnp_reg)
                    begin
                        hnp_next = 1'b0;
                        dig_next = 1'b1;
                    end
                    else
                    begin
                        hnp_next = 1'b1;
                    end
                end
                else if (is_ws)
                begin
                    phase_next = (dig_reg && !hnp_reg) ? PH_DONE : PH_ERR;
                end
                else
                begin
                    phase_next = PH_ERR;
                end
            end
            PH_BIN:
            begin
                if ((c == CH_ZERO) || (c == CH_ONE))
                begin
                    acc_next = {acc_reg[VB-2:0], c[0]};
                    dig_next = 1'b1;
                end
                else if (is_ws)
                begin
                    phase_next = (dig_reg && !hnp_reg) ? PH_DONE : PH_ERR;
                end
                else
                begin
                    phase_next = PH_ERR;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_ERR;
            end
        endcase
    end

    // Verdict on the argument as it stands after this character.
    always_comb
    begin
        if (phase_next == PH_DONE)
        begin
            ok_now = 1'b1;
        end
        else if ((phase_next == PH_ERR) || (phase_next == PH_SKIP))
        begin
            ok_now = 1'b0;
        end
        else
        begin
            ok_now = dig_next && !hnp_next;
        end
        finish.fire     = take && beat.last_char;
        finish.ok       = ok_now;
        finish.negative = neg_next;
        finish.acc      = acc_next;
    end

    // Parser state; a last character returns everything to the reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            hnp_reg   <= 1'b0;
            dig_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (beat.last_char)
            begin
                phase_reg <= PH_SKIP;
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
                hnp_reg   <= 1'b0;
                dig_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                hnp_reg   <= hnp_next;
                dig_reg   <= dig_next;
            end
        end
    end

endmodule

// ===== hw/rtl/rpip_fmt.sv =====
// ----------------------------------------------------------------------------
// rpip_fmt
// Applies the sign, widens to 32 bits and holds the result beat.
// ----------------------------------------------------------------------------
module rpip_fmt
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rpip_pkg::finish_t      finish,
    input  logic                   result_ready,
    output logic                   result_valid,
    output rpip_pkg::result_beat_t result
);

    localparam int VB = rpip_pkg::VALUE_BITS;
    localparam int RB = rpip_pkg::RESULT_BITS;

    logic [VB-1:0]        signed_acc;
    logic [RB-1:0]        wide_value;
    logic                 valid_reg, valid_next;
    rpip_pkg::result_beat_t result_reg, result_next;

    // Negate modulo the accumulator width.
    assign signed_acc = finish.negative ? (VB'(0) - finish.acc) : finish.acc;

    // Sign-extend or truncate to the result width.
    generate
        if (VB >= RB)
        begin : g_trunc
            assign wide_value = signed_acc[RB-1:0];
        end
        else
        begin : g_ext
            assign wide_value = {{(RB-VB){signed_acc[VB-1]}}, signed_acc};
        end
    endgenerate

    always_comb
    begin
        result_next = result_reg;
        valid_next  = valid_reg;
        if (finish.fire)
        begin
            result_next.parse_ok = finish.ok;
            result_next.value    = finish.ok ? wide_value : '0;
            valid_next           = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== hw/rtl/radix_prefixed_integer_parser.sv =====
// ----------------------------------------------------------------------------
// radix_prefixed_integer_parser
// Streaming ASCII integer parser: decimal with optional minus, 0x hex in
// whole bytes, 0b binary; one result beat per argument on its last character.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------
//  char     | char_valid / char_ready    | char_beat (char_code, last_char)
//  result   | result_valid / result_ready| result (parse_ok, value)
//
// One character beat is taken per cycle while char_ready is high; the parser
// state updates at the edge that takes it, through one shift-add of the accumulator.
// A last character loads the result register at the edge that takes it, so
// the result beat is offered from the next cycle, and the same edge resets
// the parser, so the next argument may start on the following cycle if result_ready is high.
// char_ready drops only while a result waits and result_ready is low.
// rst_n clears the parser state and the result valid flag asynchronously.
// ----------------------------------------------------------------------------
module radix_prefixed_integer_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_ready,
    input  rpip_pkg::char_beat_t   char_beat,
    output logic                   result_valid,
    input  logic                   result_ready,
    output rpip_pkg::result_beat_t result
);

    logic              take;
    rpip_pkg::finish_t finish;

    // A beat is taken whenever the result register can accept a new result.
    assign char_ready = !result_valid || result_ready;
    assign take       = char_valid && char_ready;

    rpip_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .beat   (char_beat),
        .finish (finish)
    );

    rpip_fmt u_fmt
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .finish       (finish),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== bench/radix_prefixed_integer_parser_tb.sv =====
// ----------------------------------------------------------------------------
// radix_prefixed_integer_parser_tb
// Self-checking bench for the streaming integer parser. Character beats are
// sent in bursts with random gaps while the result side stalls on a pattern
// of its own. A scoreboard parses the same characters and checks every result
// beat against its own prediction. A short directed set comes first, then
// mostly well-formed decimal, hex and binary arguments mixed with noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Parser phases of the predictor.
typedef enum logic [3:0] {
    P_SKIP,
    P_ZERO,
    P_SIGN,
    P_DEC,
    P_HEX,
    P_BIN,
    P_DONE,
    P_ERR
} parse_phase_t;

typedef logic [7:0] text_t[$];

localparam logic [7:0] CH_SPACE = 8'h20;
localparam logic [7:0] CH_TAB   = 8'h09;
localparam logic [7:0] CH_LF    = 8'h0A;

// Scoreboard: parses accepted characters and holds the results they imply.
class parse_scoreboard;

    parse_phase_t                      phase;
    logic [rpip_pkg::VALUE_BITS-1:0]   acc;
    bit                                negative;
    bit                                nibble_pending;
    bit                                have_digits;
    rpip_pkg::result_beat_t            awaited_results[$];
    int unsigned                       mismatches;
    int unsigned                       chars_seen;
    int unsigned                       results_checked;
    int unsigned                       ok_results;

    function new();
        restart();
        mismatches      = 0;
        chars_seen      = 0;
        results_checked = 0;
        ok_results      = 0;
    endfunction

    function void restart();
        phase          = P_SKIP;
        acc            = '0;
        negative       = 1'b0;
        nibble_pending = 1'b0;
        have_digits    = 1'b0;
    endfunction

    // Whitespace closes the number; it is only good with digits and no lone nibble.
    function void end_number();
        phase = (have_digits && !nibble_pending) ? P_DONE : P_ERR;
    endfunction

    function int unsigned pending();
        return awaited_results.size();
    endfunction

    // Advance the parser by one accepted character beat.
    function void note_char(rpip_pkg::char_beat_t beat);
        logic [7:0]                             c;
        logic [3:0]                             nib;
        bit                                     is_dec;
        bit                                     is_ws;
        bit                                     is_hex;
        bit                                     ok;
        logic signed [rpip_pkg::VALUE_BITS-1:0] signed_acc;
        rpip_pkg::result_beat_t                 res;

        c = beat.char_code;
        chars_seen++;
        is_dec = (c >= "0" && c <= "9");
        is_ws  = (c == CH_SPACE || c == CH_TAB || c == CH_LF);
        is_hex = 1'b1;
        if (is_dec)
            nib = 4'(c - "0");
        else if (c >= "a" && c <= "f")
            nib = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F")
            nib = 4'(c - "A" + 8'd10);
        else
        begin
            is_hex = 1'b0;
            nib    = 4'd0;
        end

        if (phase == P_SKIP && c == "-")
            negative = 1'b1;

        case (phase)
            P_SKIP:
            begin
                if (is_ws)
                    ;
                else if (c == "0")
                begin
                    phase       = P_ZERO;
                    have_digits = 1'b1;
                end
                else if (c == "-")
                    phase = P_SIGN;
                else if (is_dec)
                begin
                    acc         = rpip_pkg::VALUE_BITS'(nib);
                    have_digits = 1'b1;
                    phase       = P_DEC;
                end
                else
                    phase = P_ERR;
            end
            P_ZERO:
            begin
                if (c == "x")
                begin
                    phase       = P_HEX;
                    have_digits = 1'b0;
                end
                else if (c == "b")
                begin
                    phase       = P_BIN;
                    have_digits = 1'b0;
                end
                else if (is_dec)
                begin
                    acc   = rpip_pkg::VALUE_BITS'(nib);
                    phase = P_DEC;
                end
                else if (is_ws)
                    end_number();
                else
                    phase = P_ERR;
            end
            P_SIGN, P_DEC:
            begin
                if (is_dec)
                begin
                    acc         = rpip_pkg::VALUE_BITS'(acc * 10 + nib);
                    have_digits = 1'b1;
                    phase       = P_DEC;
                end
                else if (is_ws)
                    end_number();
                else
                    phase = P_ERR;
            end
            P_HEX:
            begin
                if (is_hex)
                begin
                    acc = {acc[rpip_pkg::VALUE_BITS-5:0], nib};
                    if (nibble_pending)
                    begin
                        nibble_pending = 1'b0;
                        have_digits    = 1'b1;
                    end
                    else
                        nibble_pending = 1'b1;
                end
                else if (is_ws)
                    end_number();
                else
                    phase = P_ERR;
            end
            P_BIN:
            begin
                if (c == "0" || c == "1")
                begin
                    acc         = {acc[rpip_pkg::VALUE_BITS-2:0], nib[0]};
                    have_digits = 1'b1;
                end
                else if (is_ws)
                    end_number();
                else
                    phase = P_ERR;
            end
            P_DONE:
                ;
            default:
                phase = P_ERR;
        endcase

        // The last character closes the argument and yields one result.
        if (beat.last_char)
        begin
            case (phase)
                P_DONE:        ok = 1'b1;
                P_ERR, P_SKIP: ok = 1'b0;
                default:       ok = have_digits && !nibble_pending;
            endcase
            res.parse_ok = ok;
            res.value    = '0;
            if (ok)
            begin
                signed_acc = negative ? -acc : acc;
                res.value  = rpip_pkg::RESULT_BITS'(signed_acc);
            end
            awaited_results.push_back(res);
            restart();
        end
    endfunction

    // Compare one accepted result beat with the oldest prediction.
    function void check_result(rpip_pkg::result_beat_t got);
        rpip_pkg::result_beat_t want;

        if (awaited_results.size() == 0)
        begin
            $error("unexpected result beat: parse_ok=%0d value=%0d", got.parse_ok, got.value);
            mismatches++;
            return;
        end
        want = awaited_results.pop_front();
        results_checked++;
        if (want.parse_ok)
            ok_results++;
        if (got.parse_ok !== want.parse_ok)
        begin
            $error("parse_ok: expected %0d, got %0d", want.parse_ok, got.parse_ok);
            mismatches++;
        end
        if (got.value !== want.value)
        begin
            $error("value: expected %0d, got %0d", want.value, got.value);
            mismatches++;
        end
    endfunction

endclass

module radix_prefixed_integer_parser_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 16;
    localparam int CHAR_TARGET = 800;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   char_valid   = 1'b0;
    logic                   char_ready;
    rpip_pkg::char_beat_t   char_beat    = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    rpip_pkg::result_beat_t result;

    parse_scoreboard sb;
    int unsigned     burst_left  = 0;
    int unsigned     chars_sent  = 0;
    int unsigned     args_sent   = 0;
    int unsigned     idle_cycles = 0;
    logic [9:0]      rx_cycle    = '0;

    radix_prefixed_integer_parser uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_beat    (char_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side stall pattern: always ready, random, one in four, long stalls.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[9:8])
            2'd0:    result_ready <= 1'b1;
            2'd1:    result_ready <= 1'($urandom_range(0, 1));
            2'd2:    result_ready <= (rx_cycle[1:0] == 2'd0);
            default: result_ready <= rx_cycle[4];
        endcase
    end

    // Beat monitor and watchdog on cycles with no beat moving.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && char_ready)
                sb.note_char(char_beat);
            if (result_valid && result_ready)
                sb.check_result(result);
            if ((char_valid && char_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $error("no beat moved for %0d cycles, %0d results outstanding",
                       STALL_LIMIT, sb.pending());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Send one character beat, opening a new burst after a random gap.
    task automatic send_beat(input rpip_pkg::char_beat_t b);
        int unsigned gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        char_beat  <= b;
        char_valid <= 1'b1;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
    endtask

    // Send a whole argument, marking its final character.
    task automatic send_argument(input text_t t);
        rpip_pkg::char_beat_t b;

        for (int i = 0; i < t.size(); i++)
        begin
            b.char_code = t[i];
            b.last_char = (i == t.size() - 1);
            send_beat(b);
        end
        chars_sent += t.size();
        args_sent++;
    endtask

    task automatic send_text(input string s);
        text_t t;

        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        send_argument(t);
    endtask

    // Hold the sender off until every predicted result has been taken.
    task automatic drain_results();
        char_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Build one random argument: mostly well-formed numbers, some noise and damage.
    function automatic text_t random_argument();
        text_t       t;
        int unsigned form;
        int unsigned n;
        int unsigned pos;
        logic [3:0]  v;

        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                t.push_back($urandom_range(0, 2) == 0 ? CH_TAB :
                            ($urandom_range(0, 1) ? CH_LF : CH_SPACE));
        form = $urandom_range(0, 9);
        if (form <= 2)
        begin
            if ($urandom_range(0, 2) == 0)
                t.push_back("-");
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
            repeat (n)
                t.push_back(8'("0" + $urandom_range(0, 9)));
        end
        else if (form <= 5)
        begin
            t.push_back("0");
            t.push_back("x");
            repeat (2 * $urandom_range(1, 5))
            begin
                v = 4'($urandom_range(0, 15));
                if (v < 10)
                    t.push_back(8'("0" + v));
                else
                    t.push_back(8'(($urandom_range(0, 1) ? "A" : "a") + v - 10));
            end
        end
        else if (form <= 7)
        begin
            t.push_back("0");
            t.push_back("b");
            repeat ($urandom_range(1, 40))
                t.push_back($urandom_range(0, 1) ? "1" : "0");
        end
        else if (form == 8)
        begin
            if ($urandom_range(0, 1))
                t.push_back("-");
            t.push_back("0");
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                t.push_back(8'($urandom_range(0, 255)));
        end

        // Trailing whitespace, sometimes followed by junk that must be ignored.
        if ($urandom_range(0, 3) == 0)
        begin
            t.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            repeat ($urandom_range(0, 4))
                t.push_back(8'($urandom_range(0, 255)));
        end

        // Occasional damage: a stray byte, a dropped character or a cut short tail.
        if (form != 9 && $urandom_range(0, 7) == 0)
        begin
            pos = $urandom_range(0, t.size() - 1);
            case ($urandom_range(0, 2))
                0:       t[pos] = 8'($urandom_range(0, 255));
                1:       t.delete(pos);
                default: while (t.size() > pos) void'(t.pop_back());
            endcase
            if (t.size() == 0)
                t.push_back(CH_SPACE);
        end
        return t;
    endfunction

    initial
    begin
        text_t t;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed arguments: whitespace, lone zero, prefixes, signs and wrap-around.
        send_text(" \t\n7");
        send_text("0");
        send_text("0 9");
        send_text("-0");
        send_text("012");
        send_text("-");
        send_text("- 5");
        send_text("0x");
        send_text("0b");
        send_text("0x 1");
        send_text("0xA");
        send_text("0x1 2");
        send_text("0xaBcDeF01");
        send_text("0xFFffFFff");
        send_text("0X1");
        send_text("0B1");
        send_text("0b1011");
        send_text("-0x1");
        send_text("-2147483648");
        send_text("4294967297");
        send_text("12 junk");
        send_text("1\015");
        send_text(" ");
        t = '{8'h00};
        send_argument(t);
        t = '{8'h31, 8'hFF};
        send_argument(t);
        drain_results();

        // Random arguments, with a full pause for results now and then.
        while (chars_sent < CHAR_TARGET)
        begin
            send_argument(random_argument());
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Sent %0d arguments in %0d character beats; %0d results checked.",
                 args_sent, sb.chars_seen, sb.results_checked);
        $display("%0d parsed as numbers, %0d rejected; %0d mismatches.",
                 sb.ok_results, sb.results_checked - sb.ok_results, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
